// ----- hw/rtl/cop0e_pkg.sv -----
package cop0e_pkg;

    localparam logic [31:0] VecBaseNormal = 32'h8000_0000;
    localparam logic [31:0] VecBaseBoot   = 32'hBFC0_0200;
    localparam logic [31:0] VecReset      = 32'hBFC0_0000;
    localparam logic [31:0] TimerCode     = 32'h0080_8000;
    localparam logic [31:0] TimerWindow   = 32'd1000;

    localparam logic [31:0] OffTlbRefill  = 32'h0000_0000;
    localparam logic [31:0] OffPerf       = 32'h0000_0080;
    localparam logic [31:0] OffDebug      = 32'h0000_0100;
    localparam logic [31:0] OffGeneral    = 32'h0000_0180;
    localparam logic [31:0] OffInterrupt  = 32'h0000_0200;

    localparam logic [2:0] CfgBootVectors  = 3'd0;
    localparam logic [2:0] CfgDebugVectors = 3'd1;
    localparam logic [2:0] CfgErrorLevel   = 3'd2;
    localparam logic [2:0] CfgTimerEnable  = 3'd3;
    localparam logic [2:0] CfgCompareValue = 3'd4;

    // code[17:15] classes at error level
    localparam logic [2:0] ErlSelReset = 3'd0;
    localparam logic [2:0] ErlSelPerf  = 3'd2;
    localparam logic [2:0] ErlSelDebug = 3'd3;
    localparam logic [2:0] ErlSelNmi   = 3'd1;

    // code[6:2] classes at levels 0-1
    localparam logic [4:0] SelInterrupt = 5'd0;
    localparam logic [4:0] SelTlbLo     = 5'd2;
    localparam logic [4:0] SelTlbHi     = 5'd3;

    typedef struct packed {
        logic        boot_vectors;
        logic        debug_vectors;
        logic        error_level;
        logic        timer_enable;
        logic [31:0] compare_value;
        logic [31:0] window_end;
    } cfg_t;

    typedef struct packed {
        logic        exl;
        logic [31:0] epc;
        logic [31:0] cause;
        logic [31:0] count;
        logic [31:0] last_cycle;
    } state_t;

    typedef struct packed {
        logic        redirect;
        logic [31:0] next_pc;
    } result_t;

endpackage

// ----- hw/rtl/cop0_exception_entry_and_timer.sv -----
// Throughput: one item per cycle unless a result is held waiting on m_ready;
// the input and result registers form a
// two-stage pipe, and CP0 state is updated as an item moves to the result.
// Reset (synchronous, aresetn low): pipe empty, exl/epc/cause/count and the
// last tick cycle cleared, BEV=1, DEV=0, ERL=1, timer off, compare 0.
module cop0_exception_entry_and_timer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [31:0] s_exc_code,
    input  logic        s_in_delay_slot,
    input  logic [31:0] s_current_pc,
    input  logic [31:0] s_cycle_now,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_redirect,
    output logic [31:0] m_next_pc,
    output logic [31:0] m_epc_out,
    output logic [31:0] m_cause_out,
    output logic        m_exl_out,
    output logic [31:0] m_count_out
);

    cop0e_pkg::cfg_t    cfg_reg;
    cop0e_pkg::state_t  state_reg;
    cop0e_pkg::state_t  state_next;
    cop0e_pkg::result_t result;

    logic        in_valid_reg;
    logic        cmd_reg;
    logic [31:0] exc_code_reg;
    logic        delay_slot_reg;
    logic [31:0] pc_reg;
    logic [31:0] cycle_reg;

    logic        m_valid_reg;
    logic        redirect_reg;
    logic [31:0] next_pc_reg;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.boot_vectors  <= 1'b1;
            cfg_reg.debug_vectors <= 1'b0;
            cfg_reg.error_level   <= 1'b1;
            cfg_reg.timer_enable  <= 1'b0;
            cfg_reg.compare_value <= 32'h0;
            cfg_reg.window_end    <= cop0e_pkg::TimerWindow;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                cop0e_pkg::CfgBootVectors:  cfg_reg.boot_vectors  <= cfg_data[0];
                cop0e_pkg::CfgDebugVectors: cfg_reg.debug_vectors <= cfg_data[0];
                cop0e_pkg::CfgErrorLevel:   cfg_reg.error_level   <= cfg_data[0];
                cop0e_pkg::CfgTimerEnable:  cfg_reg.timer_enable  <= cfg_data[0];
                cop0e_pkg::CfgCompareValue: begin
                    cfg_reg.compare_value <= cfg_data;
                    // window end wraps mod 2^32; a wrapped window matches nothing
                    cfg_reg.window_end    <= cfg_data + cop0e_pkg::TimerWindow;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd_reg        <= s_cmd;
            exc_code_reg   <= s_exc_code;
            delay_slot_reg <= s_in_delay_slot;
            pc_reg         <= s_current_pc;
            cycle_reg      <= s_cycle_now;
        end
    end

    cop0e_entry u_entry (
        .cfg           (cfg_reg),
        .state         (state_reg),
        .cmd           (cmd_reg),
        .exc_code      (exc_code_reg),
        .in_delay_slot (delay_slot_reg),
        .current_pc    (pc_reg),
        .cycle_now     (cycle_reg),
        .state_next    (state_next),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            redirect_reg <= result.redirect;
            next_pc_reg  <= result.next_pc;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_redirect  = redirect_reg;
    assign m_next_pc   = next_pc_reg;
    assign m_epc_out   = state_reg.epc;
    assign m_cause_out = state_reg.cause;
    assign m_exl_out   = state_reg.exl;
    assign m_count_out = state_reg.count;

`ifndef SYNTH
    a_exl_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(state_reg.exl))
        else $error("exl cleared outside reset");

    a_delay_flag_exl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && state_reg.cause[31]) |-> state_reg.exl)
        else $error("delay flag set without exl");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("result lost after advance");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(pc_reg)))
        else $error("stalled input item dropped");

    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without downstream backpressure");
`endif

endmodule

// ----- hw/rtl/cop0e_entry.sv -----
module cop0e_entry (
    input  cop0e_pkg::cfg_t    cfg,
    input  cop0e_pkg::state_t  state,
    input  logic               cmd,
    input  logic [31:0]        exc_code,
    input  logic               in_delay_slot,
    input  logic [31:0]        current_pc,
    input  logic [31:0]        cycle_now,
    output cop0e_pkg::state_t  state_next,
    output cop0e_pkg::result_t result
);

    logic [31:0] count_tick;
    logic        timer_hit;
    logic        take;
    logic [31:0] code;
    logic [4:0]  sel_lo;
    logic [2:0]  sel_erl;
    logic        nmi_path;
    logic [31:0] offset;
    logic [31:0] base;

    assign count_tick = state.count + (cycle_now - state.last_cycle);
    assign timer_hit  = cfg.timer_enable && (count_tick >= cfg.compare_value)
                        && (count_tick < cfg.window_end);
    assign take       = !cmd || timer_hit;
    assign code       = cmd ? cop0e_pkg::TimerCode : exc_code;
    assign sel_lo     = code[6:2];
    assign sel_erl    = code[17:15];
    assign nmi_path   = cfg.error_level &&
                        (sel_erl == cop0e_pkg::ErlSelReset || sel_erl == cop0e_pkg::ErlSelNmi);

    always_comb begin
        if (!cfg.error_level) begin
            if (sel_lo == cop0e_pkg::SelTlbLo || sel_lo == cop0e_pkg::SelTlbHi) begin
                offset = cop0e_pkg::OffTlbRefill;
            end else if (sel_lo == cop0e_pkg::SelInterrupt) begin
                offset = cop0e_pkg::OffInterrupt;
            end else begin
                offset = cop0e_pkg::OffGeneral;
            end
            base = cfg.boot_vectors ? cop0e_pkg::VecBaseBoot : cop0e_pkg::VecBaseNormal;
        end else begin
            if (sel_erl == cop0e_pkg::ErlSelPerf) begin
                offset = cop0e_pkg::OffPerf;
            end else if (sel_erl == cop0e_pkg::ErlSelDebug) begin
                offset = cop0e_pkg::OffDebug;
            end else begin
                offset = cop0e_pkg::OffGeneral;
            end
            base = cfg.debug_vectors ? cop0e_pkg::VecBaseBoot : cop0e_pkg::VecBaseNormal;
        end
        if (state.exl) begin
            offset = cop0e_pkg::OffGeneral;
        end
    end

    always_comb begin
        state_next       = state;
        result.redirect  = take;
        result.next_pc   = current_pc;
        if (cmd) begin
            state_next.count      = count_tick;
            state_next.last_cycle = cycle_now;
        end
        if (take) begin
            state_next.cause = {16'h0000, code[15:0]};
            if (nmi_path) begin
                result.next_pc = cop0e_pkg::VecReset;
            end else begin
                result.next_pc = base + offset;
                if (!state.exl) begin
                    state_next.exl      = 1'b1;
                    state_next.epc      = in_delay_slot ? current_pc - 32'd4 : current_pc;
                    state_next.cause[31] = in_delay_slot;
                end
            end
        end
    end

endmodule
